[sv/assert_macros.svh]
// assertion helpers shared by the rtl files
// both sample on clock and are off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BSR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bsr check failed");

// next-cycle implication
`define BSR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bsr check failed");

`endif

[sv/bsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// shared widths, codes and types of the button sequence recognizer
// ----------------------------------------------------------------------------
package bsr_pkg;

   localparam int HISTORY_DEPTH = 4;
   localparam int COUNT_W       = $clog2(HISTORY_DEPTH + 1);

   localparam int BUTTON_W    = 2;
   localparam int TIME_W      = 32;
   localparam int WINDOW_W    = 16;
   localparam int FLASH_W     = 4;
   localparam int CMD_W       = 3;
   localparam int ACT_W       = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // input item kinds
   localparam logic KIND_PRESS  = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   // button codes
   localparam logic [BUTTON_W-1:0] BTN_A = BUTTON_W'(0);
   localparam logic [BUTTON_W-1:0] BTN_B = BUTTON_W'(1);

   // pending actions
   localparam logic [ACT_W-1:0] ACT_NONE     = ACT_W'(0);
   localparam logic [ACT_W-1:0] ACT_OBEY     = ACT_W'(1);
   localparam logic [ACT_W-1:0] ACT_AMBER    = ACT_W'(2);
   localparam logic [ACT_W-1:0] ACT_DEGRADED = ACT_W'(3);

   // output commands
   localparam logic [CMD_W-1:0] CMD_NONE      = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_FLASH     = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_REJECT    = CMD_W'(2);
   localparam logic [CMD_W-1:0] CMD_RED       = CMD_W'(3);
   localparam logic [CMD_W-1:0] CMD_AMBER     = CMD_W'(4);
   localparam logic [CMD_W-1:0] CMD_EXIT_DEG  = CMD_W'(5);
   localparam logic [CMD_W-1:0] CMD_ENTER_DEG = CMD_W'(6);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_WINDOW = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_WINDOW  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_REJECT       = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_OBEY_FLASH   = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] REG_AMBER_FLASH  = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] REG_DEG_FLASH    = CSR_INDEX_W'(5);

   // register reset values
   localparam logic [WINDOW_W-1:0] SHORT_WINDOW_RESET = WINDOW_W'(12000);
   localparam logic [WINDOW_W-1:0] LONG_WINDOW_RESET  = WINDOW_W'(18000);
   localparam logic [WINDOW_W-1:0] REJECT_RESET       = WINDOW_W'(2000);
   localparam logic [FLASH_W-1:0]  OBEY_FLASH_RESET   = FLASH_W'(2);
   localparam logic [FLASH_W-1:0]  AMBER_FLASH_RESET  = FLASH_W'(3);
   localparam logic [FLASH_W-1:0]  DEG_FLASH_RESET    = FLASH_W'(4);

   typedef struct packed {
      logic                kind;
      logic [BUTTON_W-1:0] button;
      logic [TIME_W-1:0]   time_ms;
      logic                menu_open;
      logic                signal_busy;
      logic                degraded_ok;
      logic                degraded_governs;
      logic                light_in_fault;
   } bsr_item_type;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [FLASH_W-1:0]  flash_count;
      logic [WINDOW_W-1:0] duration_ms;
      logic                rearm_amber;
      logic                local_amber;
   } bsr_result_type;

   typedef struct packed {
      logic [WINDOW_W-1:0] short_window_ms;
      logic [WINDOW_W-1:0] long_window_ms;
      logic [WINDOW_W-1:0] reject_ms;
      logic [FLASH_W-1:0]  obey_flashes;
      logic [FLASH_W-1:0]  amber_flashes;
      logic [FLASH_W-1:0]  degraded_flashes;
   } bsr_cfg_type;

endpackage

[sv/bsr_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_req_if
// request channel: press and update items
// ----------------------------------------------------------------------------
interface bsr_req_if import bsr_pkg::*; ();

   logic                valid;
   logic                ready;
   logic                kind;
   logic [BUTTON_W-1:0] button;
   logic [TIME_W-1:0]   time_ms;
   logic                menu_open;
   logic                signal_busy;
   logic                degraded_ok;
   logic                degraded_governs;
   logic                light_in_fault;

   modport source (
      output valid, kind, button, time_ms, menu_open, signal_busy,
             degraded_ok, degraded_governs, light_in_fault,
      input  ready
   );

   modport sink (
      input  valid, kind, button, time_ms, menu_open, signal_busy,
             degraded_ok, degraded_governs, light_in_fault,
      output ready
   );

endinterface

[sv/bsr_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_rsp_if
// response channel: light commands
// ----------------------------------------------------------------------------
interface bsr_rsp_if import bsr_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [FLASH_W-1:0]  flash_count;
   logic [WINDOW_W-1:0] duration_ms;
   logic                rearm_amber;
   logic                local_amber;

   modport source (
      output valid, command, flash_count, duration_ms, rearm_amber, local_amber,
      input  ready
   );

   modport sink (
      input  valid, command, flash_count, duration_ms, rearm_amber, local_amber,
      output ready
   );

endinterface

[sv/bsr_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_csr
// window, duration and flash count registers
// ----------------------------------------------------------------------------
module bsr_csr import bsr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output bsr_cfg_type            cfg
);

   bsr_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_window_ms  <= SHORT_WINDOW_RESET;
         cfg_ff.long_window_ms   <= LONG_WINDOW_RESET;
         cfg_ff.reject_ms        <= REJECT_RESET;
         cfg_ff.obey_flashes     <= OBEY_FLASH_RESET;
         cfg_ff.amber_flashes    <= AMBER_FLASH_RESET;
         cfg_ff.degraded_flashes <= DEG_FLASH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SHORT_WINDOW: cfg_ff.short_window_ms  <= csr_wdata[WINDOW_W-1:0];
            REG_LONG_WINDOW:  cfg_ff.long_window_ms   <= csr_wdata[WINDOW_W-1:0];
            REG_REJECT:       cfg_ff.reject_ms        <= csr_wdata[WINDOW_W-1:0];
            REG_OBEY_FLASH:   cfg_ff.obey_flashes     <= csr_wdata[FLASH_W-1:0];
            REG_AMBER_FLASH:  cfg_ff.amber_flashes    <= csr_wdata[FLASH_W-1:0];
            REG_DEG_FLASH:    cfg_ff.degraded_flashes <= csr_wdata[FLASH_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/bsr_core.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// bsr_core
// press history, gesture match and pending action, one item per fire
// ----------------------------------------------------------------------------
module bsr_core import bsr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  bsr_item_type   item,
   input  bsr_cfg_type    cfg,
   output bsr_result_type result
);

   // history is a shift line, newest press at entry 0
   logic [BUTTON_W-1:0] button_ff [HISTORY_DEPTH];
   logic [TIME_W-1:0]   time_ff   [HISTORY_DEPTH];
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [ACT_W-1:0]    pending_ff, pending_in;
   logic                amber_ff, amber_in;

   logic [TIME_W-1:0]   age [HISTORY_DEPTH];
   logic [TIME_W-1:0]   long_win;
   logic [TIME_W-1:0]   short_win;
   logic [COUNT_W-1:0]  kept;
   logic [COUNT_W-1:0]  kept_cap;
   logic                quad_hit;
   logic                triple_hit;
   logic                push;
   bsr_result_type      res;

   assign long_win  = TIME_W'(cfg.long_window_ms);
   assign short_win = TIME_W'(cfg.short_window_ms);

   // ages modulo 2^32, then count of entries surviving the purge
   always_comb begin
      kept = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         age[i] = item.time_ms - time_ff[i];
         if (COUNT_W'(i) < count_ff && age[i] <= long_win) begin
            kept = COUNT_W'(i + 1);
         end
      end
   end

   // full history loses its oldest entry
   assign kept_cap = (kept == COUNT_W'(HISTORY_DEPTH)) ? COUNT_W'(HISTORY_DEPTH - 1) : kept;

   // a-b-a-b, oldest at entry 2 before the shift
   assign quad_hit = (kept_cap >= COUNT_W'(3)) &&
                     (button_ff[2] == BTN_A) && (button_ff[1] == BTN_B) &&
                     (button_ff[0] == BTN_A) && (item.button == BTN_B) &&
                     (age[2] <= long_win);

   // three of the same a or b
   assign triple_hit = (kept_cap >= COUNT_W'(2)) &&
                       ((item.button == BTN_A) || (item.button == BTN_B)) &&
                       (button_ff[1] == item.button) && (button_ff[0] == item.button) &&
                       (age[1] <= short_win);

   always_comb begin
      res        = '0;
      count_in   = count_ff;
      pending_in = pending_ff;
      amber_in   = amber_ff;
      push       = 1'b0;
      if (item.kind == KIND_PRESS) begin
         if (item.menu_open) begin
            count_in = '0;
         end else if (!item.signal_busy && pending_ff == ACT_NONE) begin
            push     = 1'b1;
            count_in = kept_cap + COUNT_W'(1);
            if (quad_hit) begin
               count_in = '0;
               if (item.degraded_ok) begin
                  pending_in      = ACT_DEGRADED;
                  res.command     = CMD_FLASH;
                  res.flash_count = cfg.degraded_flashes;
               end else begin
                  res.command     = CMD_REJECT;
                  res.duration_ms = cfg.reject_ms;
               end
            end else if (triple_hit) begin
               count_in    = '0;
               res.command = CMD_FLASH;
               if (item.button == BTN_A) begin
                  pending_in      = ACT_OBEY;
                  res.flash_count = cfg.obey_flashes;
               end else begin
                  pending_in      = ACT_AMBER;
                  res.flash_count = cfg.amber_flashes;
               end
            end
         end
      end else begin
         if (pending_ff != ACT_NONE && !item.signal_busy) begin
            pending_in = ACT_NONE;
            unique case (pending_ff)
               ACT_OBEY: begin
                  amber_in    = 1'b0;
                  res.command = item.degraded_governs ? CMD_EXIT_DEG : CMD_RED;
               end
               ACT_AMBER: begin
                  amber_in    = 1'b1;
                  res.command = item.degraded_governs ? CMD_EXIT_DEG : CMD_AMBER;
               end
               ACT_DEGRADED: begin
                  amber_in    = 1'b0;
                  res.command = CMD_ENTER_DEG;
               end
               default: ;
            endcase
         end
         res.rearm_amber = amber_in && !item.signal_busy && !item.degraded_governs &&
                           !item.light_in_fault && (res.command != CMD_AMBER);
      end
      res.local_amber = amber_in;
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pending_ff <= ACT_NONE;
         amber_ff   <= 1'b0;
      end else if (fire) begin
         count_ff   <= count_in;
         pending_ff <= pending_in;
         amber_ff   <= amber_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && push) begin
         button_ff[0] <= item.button;
         time_ff[0]   <= item.time_ms;
         for (int i = 1; i < HISTORY_DEPTH; i++) begin
            button_ff[i] <= button_ff[i-1];
            time_ff[i]   <= time_ff[i-1];
         end
      end
   end

   `BSR_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= COUNT_W'(HISTORY_DEPTH))
   `BSR_ASSERT_NEXT(a_pending_blocks_press,
      fire && (item.kind == KIND_PRESS) && (pending_ff != ACT_NONE),
      pending_ff == $past(pending_ff))
   `BSR_ASSERT_NEXT(a_gesture_clears_history,
      fire && (res.command == CMD_FLASH || res.command == CMD_REJECT),
      count_ff == '0)

endmodule

[sv/button_sequence_recognizer_top.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// button_sequence_recognizer_top
// Remote button gesture recognizer. Items arrive as beats on req_bus: a
// press (kind 0) with button code and millisecond timestamp, or a periodic
// update (kind 1) with the light status flags. Every beat in produces
// exactly one beat on rsp_bus carrying a light command, flash count, reject
// duration and the held local amber flags.
// Registers are written on csr_* (write enable, index, data); unknown indexes
// are dropped. Write only while the block is idle; it does not enforce this.
// Path: a taken beat is held in the input register, evaluated against the
// history there and registered in the result register that drives rsp_bus.
// Throughput: one beat per cycle while rsp_bus.ready is high; the history
// compare and age subtracts sit between the input and result registers.
// Stall: while rsp_bus.ready is low the result holds, one more beat may sit
// in the input register, then req_bus.ready drops.
// Reset (synchronous, high) clears the history count, pending action, held
// amber and both valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module button_sequence_recognizer_top import bsr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   bsr_req_if.sink                req_bus,
   bsr_rsp_if.source              rsp_bus
);

   bsr_cfg_type    cfg;
   bsr_item_type   req_item;
   bsr_item_type   s0_item_ff;
   logic           s0_valid_ff, s0_valid_in;
   bsr_result_type result;
   bsr_result_type out_result_ff;
   logic           out_valid_ff, out_valid_in;
   logic           advance;
   logic           fire;
   logic           req_take;

   // configuration registers
   bsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // pack the request beat
   assign req_item.kind             = req_bus.kind;
   assign req_item.button           = req_bus.button;
   assign req_item.time_ms          = req_bus.time_ms;
   assign req_item.menu_open        = req_bus.menu_open;
   assign req_item.signal_busy      = req_bus.signal_busy;
   assign req_item.degraded_ok      = req_bus.degraded_ok;
   assign req_item.degraded_governs = req_bus.degraded_governs;
   assign req_item.light_in_fault   = req_bus.light_in_fault;

   // result register frees up when empty or being taken
   assign advance  = !out_valid_ff || rsp_bus.ready;
   // input stage item is evaluated and state committed
   assign fire     = s0_valid_ff && advance;
   assign req_bus.ready = !s0_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   assign s0_valid_in  = req_take || (s0_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_item_ff <= req_item;
      end
   end

   // history, gesture match and action sequencing
   bsr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (s0_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (fire) begin
         out_result_ff <= result;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.command     = out_result_ff.command;
   assign rsp_bus.flash_count = out_result_ff.flash_count;
   assign rsp_bus.duration_ms = out_result_ff.duration_ms;
   assign rsp_bus.rearm_amber = out_result_ff.rearm_amber;
   assign rsp_bus.local_amber = out_result_ff.local_amber;

   // a stalled input stage keeps its beat
   `BSR_ASSERT_NEXT(a_stage_holds, s0_valid_ff && !advance,
      s0_valid_ff && (s0_item_ff == $past(s0_item_ff)))
   // flash count only travels with a flash command
   `BSR_ASSERT_NOW(a_flash_only_with_flash,
      out_valid_ff && (out_result_ff.command != CMD_FLASH),
      out_result_ff.flash_count == '0)
   // duration only travels with a reject
   `BSR_ASSERT_NOW(a_duration_only_with_reject,
      out_valid_ff && (out_result_ff.command != CMD_REJECT),
      out_result_ff.duration_ms == '0)

endmodule
